// ----- design/lsic_pkg.sv -----
package lsic_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_W = 64;
  localparam int ID_W  = 32;
  localparam int CAP_W = 5;

  // Default table depth and reset value of the capacity register.
  localparam int ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // First id handed out after reset.
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  // Contents of one cell, handed down the chain toward older positions.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  // Summary that ripples from the oldest cell toward the newest one.
  typedef struct packed {
    logic            valid;      // this cell holds an entry
    logic            hit_below;  // a match sits in this cell or an older one
    logic [ID_W-1:0] hit_id;     // id of that match
    logic [ID_W-1:0] tail_id;    // id of the least recent entry at or below
  } chain_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic update;
    logic miss;
    logic evict;
  } cell_ctl_t;

endpackage

// ----- design/lsic_cell.sv -----
module lsic_cell
  import lsic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             look,
  input  logic [KEY_W-1:0] look_key,
  input  cell_ctl_t        ctl,
  input  entry_t           prev,
  input  chain_t           from_below,
  output entry_t           entry,
  output chain_t           to_above
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match_r;
  logic   match_nxt;
  logic   hit_below;
  logic   is_tail;
  logic   shift;
  logic   drop;

  // Compare the incoming key against this cell when a transaction is accepted.
  assign match_nxt = look ? (entry_r.valid && (entry_r.key == look_key)) : match_r;

  // Ripple the hit position and the least recent entry toward the head.
  assign hit_below = match_r | from_below.hit_below;
  assign is_tail   = entry_r.valid && !from_below.valid;

  always_comb begin
    to_above.valid     = entry_r.valid;
    to_above.hit_below = hit_below;
    to_above.hit_id    = match_r ? entry_r.id : from_below.hit_id;
    to_above.tail_id   = is_tail ? entry_r.id : from_below.tail_id;
  end

  // A miss moves every cell one place older; a hit moves only the cells
  // between the head and the matching cell. On eviction the old tail is
  // dropped where it lands.
  assign shift = ctl.miss | hit_below;
  assign drop  = ctl.evict && prev.valid && !entry_r.valid;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.update && shift) begin
      entry_nxt       = prev;
      entry_nxt.valid = prev.valid && !drop;
    end
  end

  // Key and id carry no reset; they are only looked at while valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      match_r       <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
      match_r       <= match_nxt;
    end
    entry_r.key <= entry_nxt.key;
    entry_r.id  <= entry_nxt.id;
  end

  assign entry = entry_r;

endmodule

// ----- design/lru_signature_id_cache.sv -----
// LRU table that hands out a numeric id for each 64-bit signature key.
// Input channel: in_valid/in_ready with in_signature_key. Each accepted
// transaction yields exactly one result on out_valid/out_ready carrying
// out_entry_id, out_was_hit, out_evicted and out_evicted_id.
// Configuration: cfg_we writes cfg_wdata into the capacity register at the
// clock edge; write it only while no transaction is in flight.
// Sequencing: when a key is accepted, every cell of the chain compares it
// with its own key and the key is registered. Once the output register is
// free, the chain is moved and the result is loaded into the output register
// at the same edge. Only after that update can the next key be taken, so a
// new key is never accepted while one is in flight.
// The recency chain holds one entry per cell, newest at cell 0.
// When the receiver stalls, the result stays in the output register; one
// more key may be taken, but its chain update waits for the register to
// drain, holding in_ready low.
// Reset (synchronous, rst_n low) empties the table, sets the id counter to
// one and the capacity to 16; no clearing pass follows.
module lru_signature_id_cache
  import lsic_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] in_signature_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  out_entry_id,
  output logic             out_was_hit,
  output logic             out_evicted,
  output logic [ID_W-1:0]  out_evicted_id,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic             state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic             out_ev_r, out_ev_nxt;
  logic [ID_W-1:0]  out_ev_id_r, out_ev_id_nxt;

  logic             in_fire;
  logic             upd_fire;
  logic             hit;
  logic             evict;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [ID_W-1:0]  id_inc;
  cell_ctl_t        ctl;
  entry_t           head;
  entry_t           cell_entry [ENTRIES];
  entry_t           cell_prev  [ENTRIES];
  chain_t           chain      [ENTRIES+1];

  assign in_fire  = in_valid && in_ready;
  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // Capacity clamped to the range 1 .. ENTRIES.
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Lookup outcome from the head of the chain.
  assign hit   = chain[0].hit_below;
  assign evict = !hit && (CMP_W'(used_r) >= eff_cap) && (used_r != '0);

  always_comb begin
    ctl.update = upd_fire;
    ctl.miss   = !hit;
    ctl.evict  = evict;
    head.valid = 1'b1;
    head.key   = key_r;
    head.id    = hit ? chain[0].hit_id : next_id_r;
  end

  // Row of cells, newest at index 0.
  assign chain[ENTRIES] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_prev[i] = head;
    end else begin : g_body
      assign cell_prev[i] = cell_entry[i-1];
    end

    lsic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .look       (in_fire),
      .look_key   (in_signature_key),
      .ctl        (ctl),
      .prev       (cell_prev[i]),
      .from_below (chain[i+1]),
      .entry      (cell_entry[i]),
      .to_above   (chain[i])
    );
  end

  // Id counter skips zero when it wraps.
  assign id_inc = next_id_r + ID_W'(1);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    used_nxt      = used_r;
    next_id_nxt   = next_id_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_hit_nxt   = out_hit_r;
    out_ev_nxt    = out_ev_r;
    out_ev_id_nxt = out_ev_id_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_signature_key;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_id_nxt    = head.id;
          out_hit_nxt   = hit;
          out_ev_nxt    = evict;
          out_ev_id_nxt = evict ? chain[0].tail_id : '0;
          if (!hit) begin
            next_id_nxt = (id_inc == '0) ? ID_FIRST : id_inc;
            if (!evict) begin
              used_nxt = used_r + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      next_id_r   <= ID_FIRST;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      next_id_r   <= next_id_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    out_id_r    <= out_id_nxt;
    out_hit_r   <= out_hit_nxt;
    out_ev_r    <= out_ev_nxt;
    out_ev_id_r <= out_ev_id_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_entry_id   = out_id_r;
  assign out_was_hit    = out_hit_r;
  assign out_evicted    = out_ev_r;
  assign out_evicted_id = out_ev_id_r;

endmodule

// ----- design/lsic_checker.sv -----
module lsic_checker
  import lsic_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ID_W-1:0]  out_entry_id,
  input logic             out_was_hit,
  input logic             out_evicted,
  input logic [ID_W-1:0]  out_evicted_id
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_id)
      && $stable(out_was_hit) && $stable(out_evicted) && $stable(out_evicted_id))
    else $error("stalled result changed");

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_hit |-> !out_evicted && (out_evicted_id == '0))
    else $error("hit reported an eviction");

  // Id zero is never handed out, nor evicted.
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_id != '0) && (!out_evicted || (out_evicted_id != '0)))
    else $error("id zero reported");

  // One transaction at a time: no new key right after one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

endmodule

bind lru_signature_id_cache lsic_checker u_lsic_checker (.*);
